[design/qfrc_pkg.sv]
`default_nettype none
package qfrc_pkg;

  // pipeline depth of the binary128 adder
  localparam int ADD_STAGES = 6;
  // significand with hidden bit and guard bits
  localparam int MAN_W = 123;
  localparam int GUARD = 10;

  localparam logic [1:0] OP_SUM = 2'd0;
  localparam logic [1:0] OP_MAX = 2'd1;
  localparam logic [1:0] OP_MIN = 2'd2;

  localparam logic REG_OP_MODE = 1'b0;
  localparam logic REG_COMPLEX = 1'b1;

  localparam logic [14:0] EXP_MAX = 15'h7FFF;
  localparam logic [127:0] DEFAULT_NAN = {16'h7FFF, 1'b1, 111'd0};

  typedef logic [127:0] q128_t;

  typedef struct packed {
    q128_t ire;
    q128_t iim;
    q128_t are;
    q128_t aim;
    logic  last;
  } side_t;

  typedef struct packed {
    logic spec;
    logic sub;
    logic sign;
  } add_ctl_t;

  function automatic logic is_nan(input q128_t x);
    return (x[126:112] == EXP_MAX) && (x[111:0] != 112'd0);
  endfunction

  function automatic q128_t f_abs(input q128_t x);
    return {1'b0, x[126:0]};
  endfunction

endpackage
`default_nettype wire

[design/qfrc_add.sv]
`default_nettype none
module qfrc_add
  import qfrc_pkg::*;
(
  input  wire logic                  clk,
  input  wire logic [ADD_STAGES-1:0] en,
  input  wire q128_t                 a,
  input  wire q128_t                 b,
  output q128_t                      res
);

  // stage 1: specials, order by magnitude, unpack
  add_ctl_t         s1_ctl;
  q128_t            s1_specv;
  logic [14:0]      s1_ea;
  logic [14:0]      s1_d;
  logic [MAN_W-1:0] s1_x;
  logic [MAN_W-1:0] s1_y;

  always_ff @(posedge clk) begin
    logic        swap;
    q128_t       big;
    q128_t       sml;
    logic [14:0] ea;
    logic [14:0] eb;
    if (en[0]) begin
      swap = b[126:0] > a[126:0];
      big  = swap ? b : a;
      sml  = swap ? a : b;
      ea   = big[126:112];
      eb   = sml[126:112];
      s1_ctl.sub  <= big[127] ^ sml[127];
      s1_ctl.sign <= big[127];
      if (is_nan(a)) begin
        s1_ctl.spec <= 1'b1;
        s1_specv    <= a | (q128_t'(1) << 111);
      end else if (is_nan(b)) begin
        s1_ctl.spec <= 1'b1;
        s1_specv    <= b | (q128_t'(1) << 111);
      end else if (ea == EXP_MAX) begin
        s1_ctl.spec <= 1'b1;
        s1_specv    <= (eb == EXP_MAX && big[127] != sml[127]) ? DEFAULT_NAN : big;
      end else begin
        s1_ctl.spec <= 1'b0;
        s1_specv    <= big;
      end
      s1_x  <= {ea != 15'd0, big[111:0], {GUARD{1'b0}}};
      s1_y  <= {eb != 15'd0, sml[111:0], {GUARD{1'b0}}};
      s1_ea <= (ea == 15'd0) ? 15'd1 : ea;
      s1_d  <= ((ea == 15'd0) ? 15'd1 : ea) - ((eb == 15'd0) ? 15'd1 : eb);
    end
  end

  // stage 2: align the smaller operand, sticky into bit 0
  add_ctl_t         s2_ctl;
  q128_t            s2_specv;
  logic [14:0]      s2_ea;
  logic [MAN_W-1:0] s2_x;
  logic [MAN_W-1:0] s2_y;

  always_ff @(posedge clk) begin
    logic [MAN_W-1:0] mask;
    if (en[1]) begin
      mask = ~({MAN_W{1'b1}} << s1_d[6:0]);
      if (s1_d >= 15'(MAN_W)) begin
        s2_y <= {{(MAN_W-1){1'b0}}, |s1_y};
      end else begin
        s2_y <= (s1_y >> s1_d[6:0]) | {{(MAN_W-1){1'b0}}, |(s1_y & mask)};
      end
      s2_ctl   <= s1_ctl;
      s2_specv <= s1_specv;
      s2_ea    <= s1_ea;
      s2_x     <= s1_x;
    end
  end

  // stage 3: add or subtract
  add_ctl_t       s3_ctl;
  q128_t          s3_specv;
  logic [14:0]    s3_ea;
  logic [MAN_W:0] s3_sum;

  always_ff @(posedge clk) begin
    if (en[2]) begin
      s3_sum   <= s2_ctl.sub ? ({1'b0, s2_x} - {1'b0, s2_y}) : ({1'b0, s2_x} + {1'b0, s2_y});
      s3_ctl   <= s2_ctl;
      s3_specv <= s2_specv;
      s3_ea    <= s2_ea;
    end
  end

  // stage 4: carry fix-up or leading zero count
  add_ctl_t         s4_ctl;
  q128_t            s4_specv;
  logic             s4_zero;
  logic [15:0]      s4_ea;
  logic [MAN_W-1:0] s4_s;
  logic [6:0]       s4_sh;

  always_ff @(posedge clk) begin
    logic [6:0]  lz;
    logic [15:0] lim;
    if (en[3]) begin
      lz = 7'd0;
      for (int i = 0; i < MAN_W; i++) begin
        if (s3_sum[i]) lz = 7'(MAN_W - 1 - i);
      end
      lim = {1'b0, s3_ea} - 16'd1;
      s4_ctl   <= s3_ctl;
      s4_specv <= s3_specv;
      if (!s3_ctl.sub) begin
        s4_zero <= 1'b0;
        s4_sh   <= 7'd0;
        if (s3_sum[MAN_W]) begin
          s4_s  <= s3_sum[MAN_W:1] | {{(MAN_W-1){1'b0}}, s3_sum[0]};
          s4_ea <= {1'b0, s3_ea} + 16'd1;
        end else begin
          s4_s  <= s3_sum[MAN_W-1:0];
          s4_ea <= {1'b0, s3_ea};
        end
      end else begin
        s4_zero <= (s3_sum == '0);
        s4_s    <= s3_sum[MAN_W-1:0];
        s4_ea   <= {1'b0, s3_ea};
        s4_sh   <= ({9'd0, lz} < lim) ? lz : lim[6:0];
      end
    end
  end

  // stage 5: normalising shift
  add_ctl_t         s5_ctl;
  q128_t            s5_specv;
  logic             s5_zero;
  logic [15:0]      s5_ea;
  logic [MAN_W-1:0] s5_s;

  always_ff @(posedge clk) begin
    if (en[4]) begin
      s5_s     <= s4_s << s4_sh;
      s5_ea    <= s4_ea - {9'd0, s4_sh};
      s5_ctl   <= s4_ctl;
      s5_specv <= s4_specv;
      s5_zero  <= s4_zero;
    end
  end

  // stage 6: round to nearest even and pack
  always_ff @(posedge clk) begin
    logic [GUARD-1:0] rem;
    logic             rnd;
    logic [113:0]     m;
    logic [112:0]     m2;
    logic [15:0]      e2;
    if (en[5]) begin
      rem = s5_s[GUARD-1:0];
      rnd = (rem > 10'h200) || (rem == 10'h200 && s5_s[GUARD]);
      m   = {1'b0, s5_s[MAN_W-1:GUARD]} + {113'd0, rnd};
      if (m[113]) begin
        m2 = m[113:1] | {112'd0, m[0]};
        e2 = s5_ea + 16'd1;
      end else begin
        m2 = m[112:0];
        e2 = s5_ea;
      end
      if (s5_ctl.spec) begin
        res <= s5_specv;
      end else if (s5_zero) begin
        res <= '0;
      end else if (e2 >= {1'b0, EXP_MAX}) begin
        res <= {s5_ctl.sign, EXP_MAX, 112'd0};
      end else begin
        res <= {s5_ctl.sign, m2[112] ? e2[14:0] : 15'd0, m2[111:0]};
      end
    end
  end

endmodule
`default_nettype wire

[design/quad_float_reduce_combine.sv]
`default_nettype none
// combine step of a reduction on binary128 elements, real or complex
// input channel: in_valid / in_ready carry one incoming element and one
// accumulator element as 64-bit halves, plus last_in
// output channel: out_valid / out_ready carry the new accumulator element
// and last_out; imaginary halves read zero for real elements
// op_mode 0 adds the parts, 1 and 2 keep the element of larger or smaller
// magnitude (|re|+|im| for complex), 3 passes the accumulator through
// seven register stages, the first loaded at acceptance, lead to
// out_valid: the six-stage binary128 adder pipeline plus a select stage,
// two adder instances working side by side; one request can enter every
// cycle while in_ready is high
// each stage advances when it is empty or the next one moves, so bubbles
// close up and in_ready drops only when every stage holds a request and
// the receiver stalls
// synchronous reset clears the valid bits and both registers to zero;
// registers are meant to be written only while the block is idle
module quad_float_reduce_combine
  import qfrc_pkg::*;
(
  input  wire logic        clk,
  input  wire logic        rst,
  input  wire logic        psel,
  input  wire logic        penable,
  input  wire logic        pwrite,
  input  wire logic [2:0]  paddr,
  input  wire logic [31:0] pwdata,
  output logic      [31:0] prdata,
  output logic             pready,
  input  wire logic        in_valid,
  output logic             in_ready,
  input  wire logic [63:0] in_re_hi,
  input  wire logic [63:0] in_re_lo,
  input  wire logic [63:0] in_im_hi,
  input  wire logic [63:0] in_im_lo,
  input  wire logic [63:0] acc_re_hi,
  input  wire logic [63:0] acc_re_lo,
  input  wire logic [63:0] acc_im_hi,
  input  wire logic [63:0] acc_im_lo,
  input  wire logic        last_in,
  output logic             out_valid,
  input  wire logic        out_ready,
  output logic      [63:0] res_re_hi,
  output logic      [63:0] res_re_lo,
  output logic      [63:0] res_im_hi,
  output logic      [63:0] res_im_lo,
  output logic             last_out
);

  // configuration registers
  logic [1:0] op_mode;
  logic       complex_mode;

  assign pready = 1'b1;

  always_ff @(posedge clk) begin
    if (rst) begin
      op_mode      <= OP_SUM;
      complex_mode <= 1'b0;
    end else if (psel && penable && pwrite) begin
      case (paddr[2])
        REG_OP_MODE: op_mode      <= pwdata[1:0];
        REG_COMPLEX: complex_mode <= pwdata[0];
        default: ;
      endcase
    end
  end

  always_comb begin
    case (paddr[2])
      REG_OP_MODE: prdata = {30'd0, op_mode};
      REG_COMPLEX: prdata = {31'd0, complex_mode};
      default:     prdata = 32'd0;
    endcase
  end

  // stage valid bits and advance enables; the last stage is the output
  logic [ADD_STAGES:0] v;
  logic [ADD_STAGES:0] adv;

  always_comb begin
    adv[ADD_STAGES] = !v[ADD_STAGES] || out_ready;
    for (int k = ADD_STAGES - 1; k >= 0; k--) begin
      adv[k] = !v[k] || adv[k+1];
    end
  end

  assign in_ready  = adv[0];
  assign out_valid = v[ADD_STAGES];

  always_ff @(posedge clk) begin
    if (rst) begin
      v <= '0;
    end else begin
      if (adv[0]) v[0] <= in_valid;
      for (int k = 1; k <= ADD_STAGES; k++) begin
        if (adv[k]) v[k] <= v[k-1];
      end
    end
  end

  // operands
  q128_t ire, iim, are, aim;
  assign ire = {in_re_hi, in_re_lo};
  assign iim = {in_im_hi, in_im_lo};
  assign are = {acc_re_hi, acc_re_lo};
  assign aim = {acc_im_hi, acc_im_lo};

  // sum mode adds part by part, magnitude modes form |re|+|im| of each element
  q128_t add0_a, add0_b, add1_a, add1_b, add0_res, add1_res;

  always_comb begin
    if (op_mode == OP_SUM) begin
      add0_a = are;
      add0_b = ire;
      add1_a = aim;
      add1_b = iim;
    end else begin
      add0_a = f_abs(are);
      add0_b = f_abs(aim);
      add1_a = f_abs(ire);
      add1_b = f_abs(iim);
    end
  end

  qfrc_add u_add0 (
    .clk (clk),
    .en  (adv[ADD_STAGES-1:0]),
    .a   (add0_a),
    .b   (add0_b),
    .res (add0_res)
  );

  qfrc_add u_add1 (
    .clk (clk),
    .en  (adv[ADD_STAGES-1:0]),
    .a   (add1_a),
    .b   (add1_b),
    .res (add1_res)
  );

  // raw elements travel alongside the adders
  side_t sd [ADD_STAGES];

  always_ff @(posedge clk) begin
    if (adv[0]) sd[0] <= '{ire: ire, iim: iim, are: are, aim: aim, last: last_in};
    for (int k = 1; k < ADD_STAGES; k++) begin
      if (adv[k]) sd[k] <= sd[k-1];
    end
  end

  // select stage into the output register
  always_ff @(posedge clk) begin
    side_t sl;
    q128_t mi, ma, rre, rim;
    logic  take;
    if (adv[ADD_STAGES]) begin
      sl = sd[ADD_STAGES-1];
      mi = complex_mode ? add1_res : f_abs(sl.ire);
      ma = complex_mode ? add0_res : f_abs(sl.are);
      take = 1'b0;
      if (!is_nan(mi) && !is_nan(ma)) begin
        take = (op_mode == OP_MAX && mi > ma) || (op_mode == OP_MIN && mi < ma);
      end
      case (op_mode)
        OP_SUM: begin
          rre = add0_res;
          rim = add1_res;
        end
        OP_MAX, OP_MIN: begin
          rre = take ? sl.ire : sl.are;
          rim = take ? sl.iim : sl.aim;
        end
        default: begin
          rre = sl.are;
          rim = sl.aim;
        end
      endcase
      if (!complex_mode) rim = '0;
      res_re_hi <= rre[127:64];
      res_re_lo <= rre[63:0];
      res_im_hi <= rim[127:64];
      res_im_lo <= rim[63:0];
      last_out  <= sl.last;
    end
  end

endmodule
`default_nettype wire

[design/qfrc_check.sv]
`default_nettype none
module qfrc_check (
  input wire logic        clk,
  input wire logic        rst,
  input wire logic        in_valid,
  input wire logic        in_ready,
  input wire logic        out_valid,
  input wire logic        out_ready,
  input wire logic [63:0] res_re_hi,
  input wire logic        last_out
);

  // a waiting result stays offered
  a_out_hold: assert property (@(posedge clk) disable iff (rst)
    out_valid && !out_ready |=> out_valid)
    else $error("result dropped while stalled");

  // a waiting result keeps its upper real half and its last mark
  a_out_stable: assert property (@(posedge clk) disable iff (rst)
    out_valid && !out_ready |=> $stable(res_re_hi) && $stable(last_out))
    else $error("result changed while stalled");

  // back-pressure only when the receiver stalls a finished result
  a_ready_cause: assert property (@(posedge clk) disable iff (rst)
    !in_ready |-> out_valid && !out_ready)
    else $error("input stalled without output stall");

  // reset empties the pipeline
  a_reset_empty: assert property (@(posedge clk)
    rst |=> !out_valid)
    else $error("result after reset");

endmodule

bind quad_float_reduce_combine qfrc_check u_check (.*);
`default_nettype wire

[tb/tb_quad_float_reduce_combine.sv]
`default_nettype none
module tb_quad_float_reduce_combine;
  import qfrc_pkg::*;
  timeunit 1ns;
  timeprecision 1ps;

  // op_mode 3 has no name in the package and simply passes the accumulator on
  localparam logic [1:0] OP_PASS = 2'd3;
  localparam logic [2:0] ADDR_OP_MODE = {REG_OP_MODE, 2'b00};
  localparam logic [2:0] ADDR_COMPLEX = {REG_COMPLEX, 2'b00};
  localparam int DRAIN_CYCLES = 16;

  // one request: incoming element, accumulator element and end-of-vector mark
  typedef struct {
    q128_t ire;
    q128_t iim;
    q128_t are;
    q128_t aim;
    logic  last;
  } pair_t;

  // one combined element as the block should return it
  typedef struct {
    q128_t re;
    q128_t im;
    logic  last;
  } elem_t;

  logic        clk;
  logic        rst;
  logic        psel;
  logic        penable;
  logic        pwrite;
  logic [2:0]  paddr;
  logic [31:0] pwdata;
  logic [31:0] prdata;
  logic        pready;
  logic        in_valid;
  logic        in_ready;
  logic [63:0] in_re_hi;
  logic [63:0] in_re_lo;
  logic [63:0] in_im_hi;
  logic [63:0] in_im_lo;
  logic [63:0] acc_re_hi;
  logic [63:0] acc_re_lo;
  logic [63:0] acc_im_hi;
  logic [63:0] acc_im_lo;
  logic        last_in;
  logic        out_valid;
  logic        out_ready;
  logic [63:0] res_re_hi;
  logic [63:0] res_re_lo;
  logic [63:0] res_im_hi;
  logic [63:0] res_im_lo;
  logic        last_out;

  quad_float_reduce_combine dut (
    .clk(clk), .rst(rst),
    .psel(psel), .penable(penable), .pwrite(pwrite), .paddr(paddr),
    .pwdata(pwdata), .prdata(prdata), .pready(pready),
    .in_valid(in_valid), .in_ready(in_ready),
    .in_re_hi(in_re_hi), .in_re_lo(in_re_lo), .in_im_hi(in_im_hi), .in_im_lo(in_im_lo),
    .acc_re_hi(acc_re_hi), .acc_re_lo(acc_re_lo),
    .acc_im_hi(acc_im_hi), .acc_im_lo(acc_im_lo),
    .last_in(last_in),
    .out_valid(out_valid), .out_ready(out_ready),
    .res_re_hi(res_re_hi), .res_re_lo(res_re_lo),
    .res_im_hi(res_im_hi), .res_im_lo(res_im_lo),
    .last_out(last_out)
  );

  // shadow copy of the two registers
  logic [1:0] mode_op;
  logic       mode_cplx;

  elem_t combined_q[$];
  int    mismatches;
  int    idle_pct;
  int    hold_off;

  initial begin
    clk = 1'b0;
    forever #10 clk = ~clk;
  end

  // generous overall limit
  initial begin
    #40ms;
    $display("Simulation FAILED");
    $finish;
  end

  // ---------------------------------------------------------------------
  // binary128 arithmetic for prediction
  // ---------------------------------------------------------------------

  // right shift, bits shifted out are folded into bit 0
  function automatic logic [127:0] shr_sticky(logic [127:0] x, int unsigned n);
    logic [127:0] r;
    if (n == 0) return x;
    if (n >= 128) return {127'd0, |x};
    r = x >> n;
    if ((x & ((128'd1 << n) - 128'd1)) != 128'd0) r[0] = 1'b1;
    return r;
  endfunction

  // round-to-nearest-even addition, the accumulator is the first operand
  function automatic q128_t quad_add(q128_t acc, q128_t inc);
    q128_t        a, b, t;
    logic [127:0] x, y, s;
    logic         sa, sb;
    int unsigned  ea, eb;
    logic [9:0]   rem;
    if (is_nan(acc)) return acc | (128'd1 << 111);
    if (is_nan(inc)) return inc | (128'd1 << 111);
    a = acc;
    b = inc;
    if (f_abs(b) > f_abs(a)) begin
      t = a; a = b; b = t;
    end
    sa = a[127];
    sb = b[127];
    ea = 32'(a[126:112]);
    eb = 32'(b[126:112]);
    if (ea == EXP_MAX) begin
      if (eb == EXP_MAX && sa != sb) return DEFAULT_NAN;
      return a;
    end
    x = {15'd0, ea != 0, a[111:0]};
    y = {15'd0, eb != 0, b[111:0]};
    if (ea == 0) ea = 1;
    if (eb == 0) eb = 1;
    x = x << GUARD;
    y = shr_sticky(y << GUARD, ea - eb);
    if (sa == sb) begin
      s = x + y;
      if (s[113 + GUARD]) begin
        s = shr_sticky(s, 1);
        ea++;
      end
    end else begin
      s = x - y;
      // exact cancellation always gives +0
      if (s == 128'd0) return 128'd0;
      while (!s[112 + GUARD] && ea > 1) begin
        s = s << 1;
        ea--;
      end
    end
    rem = s[GUARD-1:0];
    s = s >> GUARD;
    if (rem > 10'h200 || (rem == 10'h200 && s[0])) s = s + 128'd1;
    if (s[113]) begin
      s = shr_sticky(s, 1);
      ea++;
    end
    // overflow saturates to infinity
    if (ea >= EXP_MAX) return {sa, EXP_MAX, 112'd0};
    return {sa, s[112] ? ea[14:0] : 15'd0, s[111:0]};
  endfunction

  function automatic elem_t combine_pair(pair_t p);
    elem_t r;
    q128_t mag_in, mag_acc;
    r.re = p.are;
    r.im = p.aim;
    r.last = p.last;
    if (mode_op == OP_SUM) begin
      r.re = quad_add(p.are, p.ire);
      if (mode_cplx) r.im = quad_add(p.aim, p.iim);
    end else if (mode_op == OP_MAX || mode_op == OP_MIN) begin
      if (mode_cplx) begin
        mag_in = quad_add(f_abs(p.ire), f_abs(p.iim));
        mag_acc = quad_add(f_abs(p.are), f_abs(p.aim));
      end else begin
        mag_in = f_abs(p.ire);
        mag_acc = f_abs(p.are);
      end
      // ties and nan magnitudes keep the accumulator
      if (!is_nan(mag_in) && !is_nan(mag_acc)) begin
        if ((mode_op == OP_MAX && mag_in > mag_acc) ||
            (mode_op == OP_MIN && mag_in < mag_acc)) begin
          r.re = p.ire;
          r.im = p.iim;
        end
      end
    end
    if (!mode_cplx) r.im = 128'd0;
    return r;
  endfunction

  // ---------------------------------------------------------------------
  // operand generation
  // ---------------------------------------------------------------------

  function automatic logic [63:0] rand64();
    return {$urandom, $urandom};
  endfunction

  function automatic q128_t rand_quad();
    logic         sgn;
    logic [111:0] frac;
    sgn = 1'($urandom_range(1));
    frac = {rand64(), rand64()};
    case ($urandom_range(11))
      0: return {sgn, 127'd0};
      1: return {sgn, EXP_MAX, 112'd0};
      2: return {sgn, EXP_MAX, frac | 112'd1};
      3: return {sgn, 15'd0, frac};
      4: return {sgn, 15'h7FFE, {112{1'b1}}};
      5: return {sgn, 15'(16383 - 4 + $urandom_range(8)), frac};
      6: return {sgn, 15'($urandom_range(3)), frac};
      7: return {sgn, 15'h7FFE - 15'($urandom_range(2)), frac};
      default: return {rand64(), rand64()};
    endcase
  endfunction

  // incoming part, often tied to the accumulator part to reach cancellation,
  // ties and alignment shifts
  function automatic q128_t rand_partner(q128_t acc);
    q128_t v;
    case ($urandom_range(9))
      0: return {~acc[127], acc[126:0]};
      1: return {$urandom_range(1) ? 1'b1 : 1'b0, acc[126:0]};
      2: begin
        v = acc;
        v[63:0] = v[63:0] ^ (64'd1 << $urandom_range(40));
        v[127] = 1'($urandom_range(1));
        return v;
      end
      3: begin
        v = {rand64(), rand64()};
        v[126:112] = acc[126:112] - 15'($urandom_range(130)) + 15'd3;
        return v;
      end
      default: return rand_quad();
    endcase
  endfunction

  function automatic pair_t rand_pair();
    pair_t p;
    p.are = rand_quad();
    p.aim = rand_quad();
    p.ire = rand_partner(p.are);
    p.iim = rand_partner(p.aim);
    p.last = $urandom_range(7) == 0;
    return p;
  endfunction

  // ---------------------------------------------------------------------
  // driving
  // ---------------------------------------------------------------------

  task automatic reg_write(logic [2:0] addr, logic [31:0] data);
    psel <= 1'b1;
    penable <= 1'b0;
    pwrite <= 1'b1;
    paddr <= addr;
    pwdata <= data;
    @(posedge clk);
    penable <= 1'b1;
    @(posedge clk);
    while (!pready) @(posedge clk);
    psel <= 1'b0;
    penable <= 1'b0;
    pwrite <= 1'b0;
    @(posedge clk);
  endtask

  // withdraws the request, waits for every outstanding result, then lets
  // the pipeline settle
  task automatic wait_idle();
    in_valid <= 1'b0;
    while (combined_q.size() != 0) @(posedge clk);
    repeat (DRAIN_CYCLES) @(posedge clk);
  endtask

  task automatic set_mode(logic [1:0] op, logic cplx);
    wait_idle();
    reg_write(ADDR_OP_MODE, 32'(op));
    reg_write(ADDR_COMPLEX, 32'(cplx));
    mode_op = op;
    mode_cplx = cplx;
  endtask

  // offers one request and holds it until accepted; the expectation is
  // queued at the accepting edge
  task automatic send_pair(pair_t p);
    while ($urandom_range(99) < idle_pct) begin
      in_valid <= 1'b0;
      @(posedge clk);
    end
    in_valid <= 1'b1;
    {in_re_hi, in_re_lo} <= p.ire;
    {in_im_hi, in_im_lo} <= p.iim;
    {acc_re_hi, acc_re_lo} <= p.are;
    {acc_im_hi, acc_im_lo} <= p.aim;
    last_in <= p.last;
    @(posedge clk);
    while (!in_ready) @(posedge clk);
    combined_q.push_back(combine_pair(p));
  endtask

  task automatic send_parts(q128_t ire, q128_t iim, q128_t are, q128_t aim, logic last);
    pair_t p;
    p.ire = ire;
    p.iim = iim;
    p.are = are;
    p.aim = aim;
    p.last = last;
    send_pair(p);
  endtask

  // ---------------------------------------------------------------------
  // result checking
  // ---------------------------------------------------------------------

  always @(posedge clk) begin
    elem_t e;
    if (!rst) begin
      if (out_valid && out_ready) begin
        if (combined_q.size() == 0) begin
          mismatches++;
          if (mismatches <= 10)
            $display("unexpected result re=%h%h im=%h%h", res_re_hi, res_re_lo,
                     res_im_hi, res_im_lo);
        end else begin
          e = combined_q.pop_front();
          if ({res_re_hi, res_re_lo} !== e.re || {res_im_hi, res_im_lo} !== e.im ||
              last_out !== e.last) begin
            mismatches++;
            if (mismatches <= 10) begin
              $display("mismatch op=%0d cplx=%0d", mode_op, mode_cplx);
              $display("  re exp %h got %h%h", e.re, res_re_hi, res_re_lo);
              $display("  im exp %h got %h%h", e.im, res_im_hi, res_im_lo);
              $display("  last exp %b got %b", e.last, last_out);
            end
          end
        end
      end
    end
  end

  // receiver: a long hold-off lets the pipeline fill and stall the sender
  always @(posedge clk) begin
    if (!rst) begin
      if (hold_off > 0) begin
        out_ready <= 1'b0;
        hold_off--;
      end else begin
        out_ready <= 1'($urandom_range(99) >= idle_pct);
      end
    end
  end

  // ---------------------------------------------------------------------
  // tests
  // ---------------------------------------------------------------------

  // sum special cases on real elements, then on complex ones
  task automatic test_sum_corners();
    q128_t one, maxf, inf, snan, sub;
    one = {1'b0, 15'h3FFF, 112'd0};
    maxf = {1'b0, 15'h7FFE, {112{1'b1}}};
    inf = {1'b0, EXP_MAX, 112'd0};
    snan = {1'b0, EXP_MAX, 112'd5};
    sub = {1'b0, 15'd0, {112{1'b1}}};
    set_mode(OP_SUM, 1'b0);
    send_parts(one, 128'd0, one, 128'd0, 1'b0);
    send_parts(maxf, 128'd0, maxf, 128'd0, 1'b0);           // overflow to infinity
    send_parts(inf, 128'd0, {1'b1, inf[126:0]}, 128'd0, 1'b0); // invalid sum
    send_parts(snan, 128'd0, one, 128'd0, 1'b0);           // incoming nan quietened
    send_parts(one, 128'd0, {1'b1, snan[126:0]}, 128'd0, 1'b0);
    send_parts({1'b1, one[126:0]}, 128'd0, one, 128'd0, 1'b0); // cancels to +0
    send_parts({1'b1, 127'd0}, 128'd0, {1'b1, 127'd0}, 128'd0, 1'b0);
    send_parts(sub, {128{1'b1}}, sub, {128{1'b1}}, 1'b1);   // subnormals carry to normal
    send_parts({128{1'b1}}, {128{1'b1}}, 128'd0, 128'd0, 1'b1);
    set_mode(OP_SUM, 1'b1);
    send_parts(one, inf, maxf, {1'b1, inf[126:0]}, 1'b1);
    send_parts(128'd1, snan, {1'b1, 127'd1}, one, 1'b0);
  endtask

  // magnitude selection: ties, nans and the pass mode
  task automatic test_magnitude_corners();
    q128_t one, two, qnan;
    one = {1'b0, 15'h3FFF, 112'd0};
    two = {1'b0, 15'h4000, 112'd0};
    qnan = DEFAULT_NAN;
    set_mode(OP_MAX, 1'b0);
    send_parts({1'b1, two[126:0]}, two, one, one, 1'b0);
    send_parts({1'b1, one[126:0]}, 128'd0, one, 128'd0, 1'b0); // tie keeps accumulator
    send_parts(qnan, 128'd0, one, 128'd0, 1'b1);
    set_mode(OP_MIN, 1'b1);
    send_parts(one, one, two, 128'd0, 1'b0);                  // tie in |re|+|im|
    send_parts(one, 128'd0, two, one, 1'b0);
    send_parts(one, qnan, two, two, 1'b1);
    set_mode(OP_PASS, 1'b1);
    send_parts(one, two, {1'b1, two[126:0]}, qnan, 1'b1);
    send_parts(two, one, one, two, 1'b0);
  endtask

  task automatic test_random_modes(int per_mode);
    logic [1:0] op;
    for (int m = 0; m < 8; m++) begin
      op = 2'(m >> 1);
      set_mode(op, 1'(m));
      // the real sum mode gets a stretch without idling on either side
      idle_pct = (m == 0) ? 0 : 15;
      repeat (per_mode) send_pair(rand_pair());
      idle_pct = 15;
    end
  endtask

  task automatic test_backpressure();
    set_mode(OP_SUM, 1'b1);
    hold_off = 80;
    repeat (40) send_pair(rand_pair());
    set_mode(OP_MAX, 1'b1);
    hold_off = 60;
    repeat (30) send_pair(rand_pair());
  endtask

  initial begin
    rst = 1'b1;
    psel = 1'b0;
    penable = 1'b0;
    pwrite = 1'b0;
    paddr = '0;
    pwdata = '0;
    in_valid = 1'b0;
    {in_re_hi, in_re_lo, in_im_hi, in_im_lo} = '0;
    {acc_re_hi, acc_re_lo, acc_im_hi, acc_im_lo} = '0;
    last_in = 1'b0;
    out_ready = 1'b0;
    mode_op = OP_SUM;
    mode_cplx = 1'b0;
    mismatches = 0;
    idle_pct = 15;
    hold_off = 0;
    repeat (6) @(posedge clk);
    rst <= 1'b0;
    @(posedge clk);

    test_sum_corners();
    test_magnitude_corners();
    test_random_modes(220);
    test_backpressure();
    // end with the reset setting restored
    set_mode(OP_SUM, 1'b0);

    wait_idle();
    if (mismatches == 0 && combined_q.size() == 0) begin
      $display("Simulation PASSED");
    end else begin
      $display("Simulation FAILED");
    end
    $finish;
  end

endmodule
`default_nettype wire
